/* rtl/ssbv_pkg.sv */
// Package for the sampled select bit vector.
// Holds default sizes, operation and status codes, states and byte helpers.
// Depends on nothing.
package ssbv_pkg;

  localparam int DEF_VECTOR_BITS = 65536;
  localparam int DEF_MAX_KEYS    = 32768;
  localparam int DEF_SAMPLE_STEP = 128;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SELECT = 2'd1,
    OP_NEXT   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_KEY = 2'd1,
    ST_NO_RANK = 2'd2,
    ST_NO_NEXT = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ZERO  = 6'b000010,
    S_ONE   = 6'b000100,
    S_SAMP  = 6'b001000,
    S_FETCH = 6'b010000,
    S_BYTE  = 6'b100000
  } state_e;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, b[i]};
    end
    return c;
  endfunction

  // Returns the index of the one of rank n within the byte.
  function automatic logic [2:0] pick8(input logic [7:0] b, input logic [2:0] n);
    logic [3:0] c;
    logic [2:0] r;
    c = 4'd0;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i] && (c == {1'b0, n})) begin
        r = 3'(i);
      end
      if (b[i]) begin
        c = c + 4'd1;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/ssbv_ram.sv */
// Generic single-port RAM with registered read data.
// Used for the bit store and the sample table; depends on nothing.
module ssbv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sampled_select_bit_vector.sv */
// Sampled select bit vector: builds a unary-coded vector from sorted keys and
// answers select-by-rank and next-one queries. Depends on ssbv_pkg, ssbv_ram.
// A load writes zero words in S_ZERO, then the new one's word in S_ONE; a query scans
// one byte per cycle in S_BYTE, save S_FETCH word reads and the select's S_SAMP read.
// Results cannot stall; they rise as busy falls, or after start if busy never rises.
// Reset clears the bit and key counters; the store contents are undefined until written.
module sampled_select_bit_vector #(
  parameter int VECTOR_BITS = ssbv_pkg::DEF_VECTOR_BITS,
  parameter int MAX_KEYS    = ssbv_pkg::DEF_MAX_KEYS,
  parameter int SAMPLE_STEP = ssbv_pkg::DEF_SAMPLE_STEP
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [14:0] key_value_i,
  input  logic        key_last_i,
  input  logic [14:0] rank_index_i,
  input  logic [15:0] bit_position_i,
  output logic        result_valid_o,
  output logic [15:0] position_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import ssbv_pkg::*;

  localparam int PW   = $clog2(VECTOR_BITS);
  localparam int WC   = VECTOR_BITS / 32;
  localparam int WA   = PW - 5;
  localparam int KW   = $clog2(MAX_KEYS) + 1;
  localparam int SH   = $clog2(SAMPLE_STEP);
  localparam int SD   = (MAX_KEYS + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
  localparam int TW   = ((KW > 15) ? KW : 15) + 1;
  localparam int QW   = ((PW > 16) ? PW : 16) + 1;
  localparam int BAW  = QW - 3;
  localparam logic [TW-1:0] VB_T = TW'(VECTOR_BITS);
  localparam logic [KW-1:0] MK_K = KW'(MAX_KEYS);

  state_e         state_q, state_d;
  logic [15:0]    range_q;
  logic [PW:0]    bw_q, bw_d;
  logic [KW-1:0]  kl_q, kl_d;
  logic [14:0]    prev_q, prev_d;
  logic           bd_q, bd_d;
  logic [31:0]    pack_q, pack_d;
  logic [31:0]    val_q, val_d;
  logic [WA-1:0]  tword_q, tword_d;
  logic [WA-1:0]  zw_q, zw_d;
  logic [BAW-1:0] ba_q, ba_d;
  logic [2:0]     lo_q, lo_d;
  logic [SH-1:0]  rem_q, rem_d;
  status_e        fail_q, fail_d;
  logic           rv_q, rv_d;
  logic [15:0]    rpos_q, rpos_d;
  status_e        rst_q, rst_d;

  logic           b_we, b_re;
  logic [WA-1:0]  b_addr;
  logic [31:0]    b_wdata, b_rdata;
  logic           s_we, s_re;
  logic [SAW-1:0] s_addr;
  logic [PW-1:0]  s_wdata, s_rdata;

  logic [PW:0]    bw_e;
  logic [KW-1:0]  kl_e;
  logic [14:0]    prev_e;
  logic [31:0]    pack_e;
  logic [TW-1:0]  target;
  logic           bad;
  logic [WA:0]    w_e, tw_e, fz_e;
  logic [7:0]     byte_v, mask_hi;
  logic [3:0]     cnt;
  logic [BAW-1:0] ba_end;
  logic           at_end, past_end;

  ssbv_ram #(.WIDTH(32), .DEPTH(WC), .AW(WA)) u_bits (
    .clk_i, .we_i(b_we), .re_i(b_re), .addr_i(b_addr), .wdata_i(b_wdata),
    .rdata_o(b_rdata)
  );

  ssbv_ram #(.WIDTH(PW), .DEPTH(SD), .AW(SAW)) u_samples (
    .clk_i, .we_i(s_we), .re_i(s_re), .addr_i(s_addr), .wdata_i(s_wdata),
    .rdata_o(s_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign bw_e   = bd_q ? '0 : bw_q;
  assign kl_e   = bd_q ? '0 : kl_q;
  assign prev_e = bd_q ? '0 : prev_q;
  assign pack_e = bd_q ? '0 : pack_q;
  assign target = TW'(key_value_i) + TW'(kl_e);
  assign w_e    = bw_e[PW:5];
  assign tw_e   = {1'b0, target[PW-1:5]};
  assign fz_e   = w_e + {{WA{1'b0}}, (bw_e[4:0] != 5'd0)};
  assign bad    = ({1'b0, key_value_i} >= range_q) ||
                  ((kl_e != '0) && (key_value_i < prev_e)) ||
                  (kl_e >= MK_K) || (target >= VB_T) || (target < TW'(bw_e));

  assign ba_end   = BAW'(bw_q[PW:3]);
  assign at_end   = (ba_q == ba_end);
  assign past_end = (ba_q > ba_end) || (at_end && (bw_q[2:0] == 3'd0));
  assign mask_hi  = at_end ? ((8'd1 << bw_q[2:0]) - 8'd1) : 8'hff;
  assign byte_v   = b_rdata[{ba_q[1:0], 3'b000} +: 8] & (8'hff << lo_q) & mask_hi;
  assign cnt      = popcount8(byte_v);

  always_comb begin
    state_d = state_q;
    bw_d    = bw_q;
    kl_d    = kl_q;
    prev_d  = prev_q;
    bd_d    = bd_q;
    pack_d  = pack_q;
    val_d   = val_q;
    tword_d = tword_q;
    zw_d    = zw_q;
    ba_d    = ba_q;
    lo_d    = lo_q;
    rem_d   = rem_q;
    fail_d  = fail_q;
    rv_d    = 1'b0;
    rpos_d  = rpos_q;
    rst_d   = rst_q;
    b_we    = 1'b0;
    b_re    = 1'b0;
    b_addr  = ba_q[WA+1:2];
    b_wdata = '0;
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_addr  = SAW'(kl_e >> SH);
    s_wdata = target[PW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (op_e'(operation_i))
            OP_LOAD: begin
              bw_d   = bw_e;
              kl_d   = kl_e;
              prev_d = prev_e;
              pack_d = pack_e;
              bd_d   = key_last_i;
              if (bad) begin
                rv_d   = 1'b1;
                rpos_d = '0;
                rst_d  = ST_BAD_KEY;
              end else begin
                s_we    = (kl_e[SH-1:0] == '0);
                kl_d    = kl_e + KW'(1);
                prev_d  = key_value_i;
                bw_d    = (PW+1)'(target) + (PW+1)'(1);
                tword_d = target[PW-1:5];
                val_d   = (32'd1 << target[4:0]) |
                          (((tw_e == w_e) && (bw_e[4:0] != 5'd0)) ? pack_e : 32'd0);
                zw_d    = fz_e[WA-1:0];
                state_d = (tw_e > fz_e) ? S_ZERO : S_ONE;
              end
            end
            OP_SELECT: begin
              if ({1'b0, rank_index_i} >= 16'(kl_q)) begin
                rv_d   = 1'b1;
                rpos_d = '0;
                rst_d  = ST_NO_RANK;
              end else begin
                s_re    = 1'b1;
                s_addr  = SAW'(rank_index_i >> SH);
                rem_d   = rank_index_i[SH-1:0];
                fail_d  = ST_NO_RANK;
                state_d = S_SAMP;
              end
            end
            OP_NEXT: begin
              ba_d    = BAW'(bit_position_i[15:3]);
              lo_d    = bit_position_i[2:0];
              rem_d   = SH'(1);
              fail_d  = ST_NO_NEXT;
              state_d = S_FETCH;
            end
            default: begin
              rv_d   = 1'b1;
              rpos_d = '0;
              rst_d  = ST_OK;
            end
          endcase
        end
      end
      S_ZERO: begin
        b_we    = 1'b1;
        b_addr  = zw_q;
        zw_d    = zw_q + WA'(1);
        if (zw_d == tword_q) begin
          state_d = S_ONE;
        end
      end
      S_ONE: begin
        b_we    = 1'b1;
        b_addr  = tword_q;
        b_wdata = val_q;
        pack_d  = val_q;
        rv_d    = 1'b1;
        rpos_d  = '0;
        rst_d   = ST_OK;
        state_d = S_IDLE;
      end
      S_SAMP: begin
        ba_d    = BAW'(s_rdata[PW-1:3]);
        lo_d    = s_rdata[2:0];
        state_d = S_FETCH;
      end
      S_FETCH: begin
        b_re    = 1'b1;
        state_d = S_BYTE;
      end
      S_BYTE: begin
        if (past_end) begin
          rv_d    = 1'b1;
          rpos_d  = '0;
          rst_d   = fail_q;
          state_d = S_IDLE;
        end else if ((SH+1)'(cnt) > (SH+1)'(rem_q)) begin
          rv_d    = 1'b1;
          rpos_d  = 16'({ba_q, pick8(byte_v, rem_q[2:0])});
          rst_d   = ST_OK;
          state_d = S_IDLE;
        end else begin
          rem_d   = rem_q - SH'(cnt);
          ba_d    = ba_q + BAW'(1);
          lo_d    = 3'd0;
          state_d = (ba_q[1:0] == 2'b11) ? S_FETCH : S_BYTE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      range_q <= 16'd32768;
      bw_q    <= '0;
      kl_q    <= '0;
      prev_q  <= '0;
      bd_q    <= 1'b0;
      pack_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        range_q <= cfg_data_i;
      end
      bw_q    <= bw_d;
      kl_q    <= kl_d;
      prev_q  <= prev_d;
      bd_q    <= bd_d;
      pack_q  <= pack_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    tword_q <= tword_d;
    zw_q    <= zw_d;
    ba_q    <= ba_d;
    lo_q    <= lo_d;
    rem_q   <= rem_d;
    fail_q  <= fail_d;
    rpos_q  <= rpos_d;
    rst_q   <= rst_d;
  end

  assign result_valid_o = rv_q;
  assign position_o     = rpos_q;
  assign status_o       = rst_q;

endmodule

/* bench/ssbv_checker.sv */
// Checker for the sampled select bit vector: watches item, result and
// register transfers, predicts each result and compares it field by field.
// Depends on ssbv_pkg.
module ssbv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  operation_i,
  input  logic [14:0] key_value_i,
  input  logic        key_last_i,
  input  logic [14:0] rank_index_i,
  input  logic [15:0] bit_position_i,
  input  logic        result_valid_i,
  input  logic [15:0] position_i,
  input  logic [1:0]  status_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          error_count_o,
  output int          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssbv_pkg::*;

  localparam int VecBits  = 65536;
  localparam int KeyLimit = 32768;
  localparam int Step     = 128;

  typedef struct packed {
    logic [15:0] position;
    status_e     status;
  } outcome_t;

  outcome_t    awaited_q[$];
  bit          vec_bit[VecBits];
  logic [15:0] sample_pos[KeyLimit / Step];
  int          bits_written;
  int          keys_loaded;
  int          prev_key;
  bit          build_done;
  int          key_range;

  function automatic outcome_t predict_outcome(op_e op, int key, bit last, int rank,
                                               int from);
    outcome_t res;
    int       target;
    int       seen;
    int       need;
    res.position = '0;
    res.status   = ST_OK;
    case (op)
      OP_LOAD: begin
        if (build_done) begin
          bits_written = 0;
          keys_loaded  = 0;
          prev_key     = 0;
          build_done   = 0;
        end
        target = key + keys_loaded;
        if (key >= key_range || (keys_loaded > 0 && key < prev_key) ||
            keys_loaded >= KeyLimit || target >= VecBits || target < bits_written) begin
          res.status = ST_BAD_KEY;
        end else begin
          while (bits_written < target) begin
            vec_bit[bits_written] = 1'b0;
            bits_written++;
          end
          if (keys_loaded % Step == 0) sample_pos[keys_loaded / Step] = 16'(target);
          vec_bit[target] = 1'b1;
          bits_written = target + 1;
          keys_loaded++;
          prev_key = key;
        end
        if (last) build_done = 1'b1;
      end
      OP_SELECT: begin
        res.status = ST_NO_RANK;
        if (rank < keys_loaded) begin
          need = rank % Step;
          seen = 0;
          for (int p = sample_pos[rank / Step]; p < bits_written; p++) begin
            if (vec_bit[p]) begin
              if (seen == need) begin
                res.position = 16'(p);
                res.status   = ST_OK;
                break;
              end
              seen++;
            end
          end
        end
      end
      OP_NEXT: begin
        res.status = ST_NO_NEXT;
        seen = 0;
        for (int p = from; p < bits_written; p++) begin
          if (vec_bit[p]) begin
            if (seen == 1) begin
              res.position = 16'(p);
              res.status   = ST_OK;
              break;
            end
            seen++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending_count_o = awaited_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      awaited_q.delete();
      bits_written  = 0;
      keys_loaded   = 0;
      prev_key      = 0;
      build_done    = 0;
      key_range     = 32768;
      error_count_o = 0;
    end else begin
      if (result_valid_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with none awaited: position %0d status %0d", $time,
                   position_i, status_i);
          error_count_o++;
        end else begin
          want = awaited_q.pop_front();
          if (want.position !== position_i) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     position_i);
            error_count_o++;
          end
          if (want.status !== status_i) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            error_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        awaited_q.push_back(predict_outcome(op_e'(operation_i), key_value_i, key_last_i,
                                            rank_index_i, bit_position_i));
      end
      if (cfg_valid_i && cfg_ready_i) key_range = cfg_data_i;
    end
  end

endmodule

/* bench/tb_sampled_select_bit_vector.sv */
// Top of the sampled select bit vector testbench: clock, reset, register
// writes and item stimulus; the verdict comes from ssbv_checker's counts.
// Depends on ssbv_pkg, sampled_select_bit_vector and ssbv_checker.
module tb_sampled_select_bit_vector;
  timeunit 1ns;
  timeprecision 1ps;
  import ssbv_pkg::*;

  localparam int CycleLimit = 50000000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  operation_i;
  logic [14:0] key_value_i;
  logic        key_last_i;
  logic [14:0] rank_index_i;
  logic [15:0] bit_position_i;
  logic        result_valid_o;
  logic [15:0] position_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  int          error_count;
  int          pending_count;
  int          cycle_count;
  int          gap_percent;
  int          range_now;
  int          keys_sent;
  int          top_pos;

  sampled_select_bit_vector i_dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .key_value_i, .key_last_i,
    .rank_index_i, .bit_position_i, .result_valid_o, .position_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  ssbv_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .operation_i, .key_value_i,
    .key_last_i, .rank_index_i, .bit_position_i, .result_valid_i(result_valid_o),
    .position_i(position_o), .status_i(status_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_data_i, .error_count_o(error_count),
    .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Entered and left at a falling edge; start stays high after the transfer.
  task automatic send_item(op_e op, int key, bit last, int rank, int pos);
    while ($urandom_range(99) < gap_percent) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start          = 1'b1;
    operation_i    = op;
    key_value_i    = 15'(key);
    key_last_i     = last;
    rank_index_i   = 15'(rank);
    bit_position_i = 16'(pos);
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic load_key(int key, bit last);
    send_item(OP_LOAD, key, last, $urandom, $urandom);
  endtask

  task automatic ask_query();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)
      send_item(OP_SELECT, $urandom, 1'($urandom), (pick < 5) ? $urandom :
                $urandom_range(0, keys_sent + 2), $urandom);
    else if (pick < 95)
      send_item(OP_NEXT, $urandom, 1'($urandom), $urandom, (pick < 50) ? $urandom :
                $urandom_range(0, top_pos + 8));
    else
      send_item(OP_NONE, $urandom, 1'($urandom), $urandom, $urandom);
  endtask

  task automatic settle_and_write(int value);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = 16'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    range_now   = value;
  endtask

  task automatic run_builds(int item_goal);
    int sent;
    int count;
    int key;
    sent = 0;
    while (sent < item_goal) begin
      count = ($urandom_range(9) == 0) ? $urandom_range(130, 300) : $urandom_range(1, 40);
      key = ($urandom_range(19) == 0) ? $urandom_range(0, range_now - 1) :
            $urandom_range(0, (range_now < 50) ? range_now - 1 : 50);
      keys_sent = 0;
      for (int j = 0; j < count; j++) begin
        key = key + $urandom_range(0, 3);
        if (key > range_now - 1) key = range_now - 1;
        if ($urandom_range(99) < 8) load_key($urandom, j == count - 1);
        else begin
          load_key(key, j == count - 1);
          keys_sent++;
          top_pos = key + keys_sent;
        end
        sent++;
        if ($urandom_range(99) < 25) begin
          ask_query();
          sent++;
        end
      end
      for (int j = 0; j < count / 2 + 2; j++) begin
        ask_query();
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = OP_NONE;
    key_value_i    = '0;
    key_last_i     = 1'b0;
    rank_index_i   = '0;
    bit_position_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    cycle_count    = 0;
    gap_percent    = 0;
    keys_sent      = 0;
    top_pos        = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    settle_and_write(32768);

    load_key(0, 1'b0);
    load_key(0, 1'b0);
    load_key(3, 1'b0);
    load_key(2, 1'b0);
    load_key(32767, 1'b0);
    send_item(OP_SELECT, 0, 0, 0, 0);
    send_item(OP_SELECT, 0, 0, 3, 0);
    send_item(OP_SELECT, 0, 0, 4, 0);
    send_item(OP_SELECT, 0, 0, 32767, 0);
    send_item(OP_NEXT, 0, 0, 0, 0);
    send_item(OP_NEXT, 0, 0, 0, 1);
    send_item(OP_NEXT, 0, 0, 0, 6);
    send_item(OP_NEXT, 0, 0, 0, 65535);
    send_item(OP_NONE, 32767, 1, 32767, 65535);
    load_key(32767, 1'b1);
    load_key(5, 1'b0);
    send_item(OP_NEXT, 0, 0, 0, 0);
    load_key(1, 1'b1);
    send_item(OP_SELECT, 0, 0, 0, 0);
    load_key(7, 1'b0);
    send_item(OP_NEXT, 0, 0, 0, 0);

    gap_percent = 21;
    run_builds(300);
    settle_and_write(1);
    load_key(0, 1'b0);
    load_key(1, 1'b1);
    gap_percent = 58;
    run_builds(150);
    settle_and_write(5000);
    run_builds(400);
    settle_and_write(32768);
    gap_percent = 0;
    run_builds(400);

    start = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sampled_select_bit_vector.f */
rtl/ssbv_pkg.sv
rtl/ssbv_ram.sv
rtl/sampled_select_bit_vector.sv
bench/ssbv_checker.sv
bench/tb_sampled_select_bit_vector.sv
